[rtl/core/bddp_pkg.sv]
// Shared types and constants for the box distance/direction priority block.
package bddp_pkg;

	localparam int CoordW  = 32;
	localparam int HeadW   = 16;
	localparam int OffW    = 33;
	localparam int SqW     = 64;
	localparam int ProdW   = 49;
	localparam int SumW    = 66;
	localparam int DotW    = 51;
	localparam int MagW    = 50;
	localparam int RootW   = 50;
	localparam int RadW    = 2 * RootW;
	localparam int RemW    = 52;
	localparam int QuoW    = 18;
	localparam int RadiusW = 31;
	localparam int WeightW = 17;
	localparam int PrioW   = 17;
	localparam int IndexW  = 3;
	localparam int CfgDataW = 32;

	// Remap constants: a = p + 2^32 + 98304, result = floor(a / 196608)
	localparam int        AccW     = 38;
	localparam logic [AccW-1:0] RemapBias = AccW'(64'd4295065600);
	localparam logic [AccW-1:0] HalfStep  = AccW'(98304);
	localparam logic [AccW-1:0] SatLimit  = AccW'(64'd12884901888);
	localparam logic [19:0] Recip3   = 20'd699051;
	localparam int          Recip3Sh = 21;
	localparam logic [WeightW-1:0] WeightOne = WeightW'(65536);
	localparam logic [PrioW-1:0]   PrioOne   = PrioW'(65536);

	typedef enum logic [IndexW-1:0] {
		REG_USE_DIST    = 3'd0,
		REG_USE_DIR     = 3'd1,
		REG_DIST_WEIGHT = 3'd2,
		REG_DIR_WEIGHT  = 3'd3,
		REG_FLATTEN_Z   = 3'd4,
		REG_MAX_RADIUS  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               use_dist;
		logic               use_dir;
		logic [WeightW-1:0] dist_w;
		logic [WeightW-1:0] dir_w;
		logic               flatten_z;
		logic [RadiusW-1:0] radius;
	} cfg_t;

	// first field in the highest bits
	typedef struct packed {
		logic signed [HeadW-1:0]  heading_z;
		logic signed [HeadW-1:0]  heading_y;
		logic signed [HeadW-1:0]  heading_x;
		logic signed [CoordW-1:0] box_max_z;
		logic signed [CoordW-1:0] box_max_y;
		logic signed [CoordW-1:0] box_max_x;
		logic signed [CoordW-1:0] box_min_z;
		logic signed [CoordW-1:0] box_min_y;
		logic signed [CoordW-1:0] box_min_x;
		logic signed [CoordW-1:0] source_z;
		logic signed [CoordW-1:0] source_y;
		logic signed [CoordW-1:0] source_x;
	} item_t;

	typedef struct packed {
		logic [RadW-1:0]  rad;
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
		logic [MagW-1:0]  mag;
		logic             neg;
	} sqrt_t;

endpackage

[rtl/core/box_distance_direction_priority.sv]
// Top level: box priority from distance/heading, one word per unstalled cycle.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  s_      | s_tvalid / s_tready  | s_tdata: 9 x 32b coords, 3 x 16b heading
//  m_      | m_tvalid / m_tready  | m_tdata: priority_res (17b)
//  cfg_    | cfg_valid/ cfg_ready | cfg_index (3b), cfg_data (32b)
//
// One word in and one out per cycle while the hold register is empty. The
// pipeline is the front stages, 50 square root cells, 18 divider cells and
// the back stages. arst_n clears the valid bits and the hold register's full
// flag and sets the configuration to its defaults. A stalled output result
// moves to a one-word hold register; the pipeline freezes only while it is full.
module box_distance_direction_priority (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// source_x, source_y, source_z, box_min_x/y/z, box_max_x/y/z, heading_x/y/z
	input  logic [335:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// priority_res [16:0], zeros above
	output logic [23:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import bddp_pkg::*;

	localparam int Stages = 3 + RootW + 1 + QuoW + 3;
	localparam int Last   = Stages - 1;

	cfg_t              cfg_q;
	logic [Stages-1:0] v_q;
	logic              en;
	logic              skid_q;
	logic [PrioW-1:0]  skid_d_q;
	logic [PrioW-1:0]  prio;
	item_t             item;
	sqrt_t             sq [0:RootW];

	logic [RadiusW-1:0] r_c;
	logic [46:0]        rq_c;
	logic               far_c;
	logic [46:0]        nd_c;

	logic [RootW-1:0]   c_rem [0:QuoW];
	logic [RootW-1:0]   c_den [0:QuoW];
	logic [QuoW-1:0]    c_num [0:QuoW];
	logic [QuoW-1:0]    c_quo [0:QuoW];
	logic [1:0]         c_tag [0:QuoW];
	logic [RadiusW-1:0] d_rem [0:QuoW];
	logic [RadiusW-1:0] d_den [0:QuoW];
	logic [QuoW-1:0]    d_num [0:QuoW];
	logic [QuoW-1:0]    d_quo [0:QuoW];
	logic [0:0]         d_tag [0:QuoW];

	logic [RootW-1:0]   c_rem_q, c_den_q;
	logic [1:0]         c_tag_q;
	logic [RadiusW-1:0] d_rem_q, d_den_q;
	logic [QuoW-1:0]    d_num_q;
	logic               d_far_q;

	assign cfg_ready = 1'b1;
	assign item      = s_tdata;
	assign en        = !skid_q;
	assign s_tready  = en;
	assign m_tvalid  = skid_q || v_q[Last];
	assign m_tdata   = {7'd0, skid_q ? skid_d_q : prio};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_dist  <= 1'b1;
			cfg_q.use_dir   <= 1'b1;
			cfg_q.dist_w    <= WeightOne;
			cfg_q.dir_w     <= WeightOne;
			cfg_q.flatten_z <= 1'b0;
			cfg_q.radius    <= RadiusW'(4194304);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_USE_DIST:    cfg_q.use_dist  <= cfg_data[0];
				REG_USE_DIR:     cfg_q.use_dir   <= cfg_data[0];
				REG_DIST_WEIGHT: cfg_q.dist_w    <= cfg_data[WeightW-1:0];
				REG_DIR_WEIGHT:  cfg_q.dir_w     <= cfg_data[WeightW-1:0];
				REG_FLATTEN_Z:   cfg_q.flatten_z <= cfg_data[0];
				REG_MAX_RADIUS:  cfg_q.radius    <= cfg_data[RadiusW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			skid_q <= 1'b0;
		end else if (!skid_q) begin
			v_q <= {v_q[Stages-2:0], s_tvalid};
			if (v_q[Last] && !m_tready) begin
				skid_q <= 1'b1;
			end
		end else if (m_tready) begin
			skid_q <= 1'b0;
		end
	end

	// hold the stalled word while the pipeline moves on
	always_ff @(posedge clk) begin
		if (!skid_q && v_q[Last] && !m_tready) begin
			skid_d_q <= prio;
		end
	end

	bddp_front u_front (
		.clk  (clk),
		.en   (en),
		.item (item),
		.cfg  (cfg_q),
		.y    (sq[0])
	);

	for (genvar k = 0; k < RootW; k++) begin : g_sqrt
		bddp_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.a   (sq[k]),
			.y   (sq[k+1])
		);
	end

	// division setup: cos = |dot| * 2^18 / root, closeness = (r * 2^16 - root) / r
	always_comb begin
		r_c   = (cfg_q.radius == '0) ? RadiusW'(1) : cfg_q.radius;
		rq_c  = {r_c, 16'd0};
		far_c = {3'd0, rq_c} <= sq[RootW].root;
		nd_c  = far_c ? '0 : rq_c - sq[RootW].root[46:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_rem_q <= sq[RootW].mag;
			c_den_q <= sq[RootW].root;
			c_tag_q <= {sq[RootW].root == '0, sq[RootW].neg};
			d_rem_q <= RadiusW'(nd_c[46:QuoW]);
			d_num_q <= nd_c[QuoW-1:0];
			d_den_q <= r_c;
			d_far_q <= far_c;
		end
	end

	assign c_rem[0] = c_rem_q;
	assign c_den[0] = c_den_q;
	assign c_num[0] = '0;
	assign c_quo[0] = '0;
	assign c_tag[0] = c_tag_q;
	assign d_rem[0] = d_rem_q;
	assign d_den[0] = d_den_q;
	assign d_num[0] = d_num_q;
	assign d_quo[0] = '0;
	assign d_tag[0] = d_far_q;

	for (genvar k = 0; k < QuoW; k++) begin : g_div
		bddp_div_cell #(.DW(RootW), .QW(QuoW), .TW(2)) u_cos (
			.clk   (clk),
			.en    (en),
			.rem_i (c_rem[k]),
			.den_i (c_den[k]),
			.num_i (c_num[k]),
			.quo_i (c_quo[k]),
			.tag_i (c_tag[k]),
			.rem_q (c_rem[k+1]),
			.den_q (c_den[k+1]),
			.num_q (c_num[k+1]),
			.quo_q (c_quo[k+1]),
			.tag_q (c_tag[k+1])
		);
		bddp_div_cell #(.DW(RadiusW), .QW(QuoW), .TW(1)) u_close (
			.clk   (clk),
			.en    (en),
			.rem_i (d_rem[k]),
			.den_i (d_den[k]),
			.num_i (d_num[k]),
			.quo_i (d_quo[k]),
			.tag_i (d_tag[k]),
			.rem_q (d_rem[k+1]),
			.den_q (d_den[k+1]),
			.num_q (d_num[k+1]),
			.quo_q (d_quo[k+1]),
			.tag_q (d_tag[k+1])
		);
	end

	bddp_back u_back (
		.clk       (clk),
		.en        (en),
		.cfg       (cfg_q),
		.cos_q     (c_quo[QuoW]),
		.root_zero (c_tag[QuoW][1]),
		.cos_neg   (c_tag[QuoW][0]),
		.close_q   (d_quo[QuoW]),
		.far       (d_tag[QuoW][0]),
		.prio_s3   (prio)
	);

`ifndef SYNTHESIS
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(v_q[Last] && !m_tready))
		else $error("hold register filled without an output stall");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && m_tready |=> !skid_q)
		else $error("hold register not drained after the word was taken");
	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_q[0])
		else $error("accepted word not tracked in the first stage");
`endif

endmodule

[rtl/core/bddp_front.sv]
// Front stages: nearest box point, offset, squares and heading dot product.
module bddp_front (
	input  logic           clk,
	input  logic           en,
	input  bddp_pkg::item_t item,
	input  bddp_pkg::cfg_t  cfg,
	output bddp_pkg::sqrt_t y
);
	import bddp_pkg::*;

	logic signed [CoordW-1:0] s_c  [3];
	logic signed [CoordW-1:0] mn_c [3];
	logic signed [CoordW-1:0] mx_c [3];
	logic signed [CoordW-1:0] nr_c [3];
	logic signed [HeadW-1:0]  h_c  [3];
	logic signed [OffW-1:0]   d_s1 [3];
	logic signed [HeadW-1:0]  h_s1 [3];
	logic [OffW-1:0]          mag_c [3];
	logic [SqW-1:0]           sq_s2 [3];
	logic signed [ProdW-1:0]  pr_s2 [3];
	logic [SumW-1:0]          sum_c;
	logic signed [DotW-1:0]   dot_c;
	logic [DotW-1:0]          dabs_c;

	always_comb begin
		s_c[0]  = item.source_x;
		s_c[1]  = item.source_y;
		s_c[2]  = cfg.flatten_z ? '0 : item.source_z;
		mn_c[0] = item.box_min_x;
		mn_c[1] = item.box_min_y;
		mn_c[2] = item.box_min_z;
		mx_c[0] = item.box_max_x;
		mx_c[1] = item.box_max_y;
		mx_c[2] = item.box_max_z;
		h_c[0]  = item.heading_x;
		h_c[1]  = item.heading_y;
		h_c[2]  = item.heading_z;
		for (int i = 0; i < 3; i++) begin
			if (s_c[i] < mn_c[i]) begin
				nr_c[i] = mn_c[i];
			end else if (s_c[i] > mx_c[i]) begin
				nr_c[i] = mx_c[i];
			end else begin
				nr_c[i] = s_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {nr_c[i][CoordW-1], nr_c[i]} - {s_c[i][CoordW-1], s_c[i]};
				h_s1[i] <= h_c[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s1[i][OffW-1] ? OffW'(-d_s1[i]) : OffW'(d_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= mag_c[i][CoordW-1:0] * mag_c[i][CoordW-1:0];
				pr_s2[i] <= d_s1[i] * h_s1[i];
			end
		end
	end

	always_comb begin
		sum_c  = SumW'(sq_s2[0]) + SumW'(sq_s2[1]) + SumW'(sq_s2[2]);
		dot_c  = DotW'(pr_s2[0]) + DotW'(pr_s2[1]) + DotW'(pr_s2[2]);
		dabs_c = dot_c[DotW-1] ? DotW'(-dot_c) : DotW'(dot_c);
	end

	// radicand is S * 2^32, padded to an even number of bit pairs
	always_ff @(posedge clk) begin
		if (en) begin
			y.rad  <= {2'b00, sum_c, 32'd0};
			y.rem  <= '0;
			y.root <= '0;
			y.mag  <= dabs_c[MagW-1:0];
			y.neg  <= dot_c[DotW-1];
		end
	end

endmodule

[rtl/core/bddp_sqrt_cell.sv]
// One root bit of the digit-by-digit square root chain.
module bddp_sqrt_cell (
	input  logic            clk,
	input  logic            en,
	input  bddp_pkg::sqrt_t a,
	output bddp_pkg::sqrt_t y
);
	import bddp_pkg::*;

	logic [RemW-1:0] cur_c;
	logic [RemW-1:0] trial_c;
	logic            ge_c;

	always_comb begin
		cur_c   = {a.rem[RemW-3:0], a.rad[RadW-1 -: 2]};
		trial_c = {a.root[RemW-3:0], 2'b01};
		ge_c    = cur_c >= trial_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y.rad  <= {a.rad[RadW-3:0], 2'b00};
			y.rem  <= ge_c ? cur_c - trial_c : cur_c;
			y.root <= {a.root[RootW-2:0], ge_c};
			y.mag  <= a.mag;
			y.neg  <= a.neg;
		end
	end

endmodule

[rtl/core/bddp_div_cell.sv]
// One quotient bit of a restoring division chain.
module bddp_div_cell #(
	parameter int DW = 50,
	parameter int QW = 18,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_i,
	input  logic [DW-1:0] den_i,
	input  logic [QW-1:0] num_i,
	input  logic [QW-1:0] quo_i,
	input  logic [TW-1:0] tag_i,
	output logic [DW-1:0] rem_q,
	output logic [DW-1:0] den_q,
	output logic [QW-1:0] num_q,
	output logic [QW-1:0] quo_q,
	output logic [TW-1:0] tag_q
);
	logic [DW:0] t_c;
	logic [DW:0] diff_c;
	logic        ge_c;

	always_comb begin
		t_c    = {rem_i, num_i[QW-1]};
		diff_c = t_c - {1'b0, den_i};
		ge_c   = t_c >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge_c ? diff_c[DW-1:0] : t_c[DW-1:0];
			den_q <= den_i;
			num_q <= {num_i[QW-2:0], 1'b0};
			quo_q <= {quo_i[QW-2:0], ge_c};
			tag_q <= tag_i;
		end
	end

endmodule

[rtl/core/bddp_back.sv]
// Back stages: weight the terms, sum, remap by (p+1)/3 and saturate.
module bddp_back (
	input  logic                          clk,
	input  logic                          en,
	input  bddp_pkg::cfg_t                cfg,
	input  logic [bddp_pkg::QuoW-1:0]     cos_q,
	input  logic                          root_zero,
	input  logic                          cos_neg,
	input  logic [bddp_pkg::QuoW-1:0]     close_q,
	input  logic                          far,
	output logic [bddp_pkg::PrioW-1:0]    prio_s3
);
	import bddp_pkg::*;

	logic [WeightW-1:0] wd_c, wr_c, close_c;
	logic [QuoW-1:0]    cosm_c;
	logic [33:0]        t1_s1;
	logic [34:0]        t2_s1;
	logic               neg_s1;
	logic [AccW-1:0]    acc_c;
	logic               lo_s2, sat_s2;
	logic [17:0]        x_s2;
	logic [37:0]        prod_c;

	always_comb begin
		wd_c    = cfg.dist_w[WeightW-1] ? WeightOne : cfg.dist_w;
		wr_c    = cfg.dir_w[WeightW-1] ? WeightOne : cfg.dir_w;
		close_c = far ? '0 : close_q[WeightW-1:0];
		cosm_c  = root_zero ? '0 : cos_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1  <= cfg.use_dist ? close_c * wd_c : '0;
			t2_s1  <= cfg.use_dir ? cosm_c * wr_c : '0;
			neg_s1 <= cos_neg;
		end
	end

	// acc = p + 2^32 + 98304; p < -2^32 (low clamp) shows as acc below the half step
	always_comb begin
		if (neg_s1) begin
			acc_c = RemapBias + AccW'(t1_s1) - AccW'(t2_s1);
		end else begin
			acc_c = RemapBias + AccW'(t1_s1) + AccW'(t2_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2  <= acc_c[AccW-1] || (acc_c < HalfStep);
			sat_s2 <= !acc_c[AccW-1] && (acc_c >= SatLimit);
			x_s2   <= acc_c[33:16];
		end
	end

	assign prod_c = x_s2 * Recip3;

	always_ff @(posedge clk) begin
		if (en) begin
			if (lo_s2) begin
				prio_s3 <= '0;
			end else if (sat_s2) begin
				prio_s3 <= PrioOne;
			end else begin
				prio_s3 <= prod_c[Recip3Sh +: PrioW];
			end
		end
	end

endmodule
